// ----- hw/rtl/fir17_pkg.sv -----
package fir17_pkg;

  // Width of one audio sample and of one filtered result
  localparam int SAMPLE_W = 32;

  // Number of taps in the band-pass coefficient table
  localparam int ROM_TAPS = 17;

  // Control that travels with one tap read into the multiply-accumulate
  typedef struct packed {
    logic valid;  // a tap read was issued this cycle
    logic first;  // first tap of the item: restart the sum
    logic last;   // last tap of the item: finish the sum
    logic live;   // the tap reaches a written sample (else it reads as zero)
  } tap_ctl_t;

  // Band-pass coefficients, signed Q0.15; taps past the table are zero
  function automatic int coef_q15(input int j);
    int c;
    case (j)
      0:       c = -23;
      1:       c = -3;
      2:       c = 56;
      3:       c = 157;
      4:       c = 305;
      5:       c = 495;
      6:       c = 711;
      7:       c = 927;
      8:       c = 1114;
      9:       c = 1239;
      10:      c = 1278;
      11:      c = 1239;
      12:      c = 1114;
      13:      c = 927;
      14:      c = 711;
      15:      c = 495;
      16:      c = 305;
      default: c = 0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/fir17_ifs.sv -----
// Input channel: one raw sample and its end-of-frame flag
interface fir17_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [fir17_pkg::SAMPLE_W-1:0] sample_in;
  logic                              frame_end_in;

  modport source (output valid, output sample_in, output frame_end_in, input ready);
  modport sink   (input valid, input sample_in, input frame_end_in, output ready);
endinterface

// Result channel: one filtered sample and the passed-through flag
interface fir17_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fir17_pkg::SAMPLE_W-1:0] filtered_out;
  logic                              frame_end_out;

  modport source (output valid, output filtered_out, output frame_end_out, input ready);
  modport sink   (input valid, input filtered_out, input frame_end_out, output ready);
endinterface

// ----- hw/rtl/fir17_ram.sv -----
module fir17_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fir17_mac.sv -----
module fir17_mac #(
  parameter int TAP_COUNT  = 17,
  parameter int COEF_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fir17_pkg::tap_ctl_t                    tap_ctl,
  input  logic [$clog2(TAP_COUNT)-1:0]           tap_idx,
  input  logic [fir17_pkg::SAMPLE_W-1:0]         rd_data,
  input  logic                                   res_take,
  output logic                                   res_valid,
  output logic signed [fir17_pkg::SAMPLE_W-1:0]  res_data
);

  localparam int TAP_W  = $clog2(TAP_COUNT);
  localparam int PROD_W = fir17_pkg::SAMPLE_W + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + TAP_W + 1;
  localparam int UP_SH  = (COEF_WIDTH >= 16) ? COEF_WIDTH - 16 : 0;
  localparam int DN_SH  = (COEF_WIDTH < 16) ? 16 - COEF_WIDTH : 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  // Scale the Q0.15 table to the coefficient width (round half up when narrowing)
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_W-1:0] j);
    int c;
    int r;
    c = fir17_pkg::coef_q15(int'(j));
    if (COEF_WIDTH >= 16) begin
      r = c <<< UP_SH;
    end else begin
      r = (c + (1 <<< (DN_SH - 1))) >>> DN_SH;
    end
    return r[COEF_WIDTH-1:0];
  endfunction

  // Tap stage: control aligned with the RAM read data
  fir17_pkg::tap_ctl_t  s1_ctl_r;
  logic [TAP_W-1:0]     s1_idx_r;

  // Product stage
  logic                     s2_valid_r;
  logic                     s2_first_r;
  logic                     s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // Accumulate and result stages
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;
  logic                     res_valid_r;
  logic signed [fir17_pkg::SAMPLE_W-1:0] res_r;
  logic signed [fir17_pkg::SAMPLE_W-1:0] res_nxt;
  logic signed [ACC_W-1:0]  shifted;

  // Multiply the sample by its coefficient; unwritten taps read as zero
  always_comb begin
    if (s1_ctl_r.live) begin
      prod_nxt = $signed(rd_data) * coef_at(s1_idx_r);
    end else begin
      prod_nxt = '0;
    end
  end

  // Add the product, restarting on the first tap
  always_comb begin
    if (s2_first_r) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // Drop the fraction and clamp to the sample range
  always_comb begin
    shifted = acc_r >>> (COEF_WIDTH - 1);
    if (shifted > SAT_HI) begin
      res_nxt = 32'sh7FFF_FFFF;
    end else if (shifted < SAT_LO) begin
      res_nxt = 32'sh8000_0000;
    end else begin
      res_nxt = shifted[fir17_pkg::SAMPLE_W-1:0];
    end
  end

  // Advance the control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_valid_r  <= 1'b0;
      s2_first_r  <= 1'b0;
      s2_last_r   <= 1'b0;
      done_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_ctl_r   <= tap_ctl;
      s2_valid_r <= s1_ctl_r.valid;
      s2_first_r <= s1_ctl_r.valid && s1_ctl_r.first;
      s2_last_r  <= s1_ctl_r.valid && s1_ctl_r.last;
      done_r     <= s2_valid_r && s2_last_r;
      if (done_r) begin
        res_valid_r <= 1'b1;
      end else if (res_take) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Hold the datapath registers
  always_ff @(posedge clk) begin
    s1_idx_r <= tap_idx;
    if (s1_ctl_r.valid) begin
      prod_r <= prod_nxt;
    end
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (done_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

// ----- hw/rtl/fir_17_tap_bandpass.sv -----
// 17-tap direct-form band-pass FIR (300 Hz to 3 kHz) for signed 32-bit samples.
// Each accepted sample is written into a circular history RAM, then one shared
// multiply-accumulate walks the history one tap per cycle, newest first, with
// the coefficients scaled to COEF_WIDTH bits. The full-precision sum is shifted
// arithmetically right by COEF_WIDTH-1 and clamped to 32 bits; the end-of-frame
// flag rides along unchanged. Taps reaching before the first sample after reset
// read as zero. One item is handled at a time: the accept cycle, one history RAM
// read per tap, then the product, accumulate and shift-and-clamp stages and the
// output load, which waits until the output register is free.
// A new sample is accepted while the previous result still waits in the output
// register.
module fir_17_tap_bandpass #(
  parameter int TAP_COUNT  = 17,
  parameter int COEF_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  fir17_in_if.sink         in_ch,
  fir17_out_if.source      out_ch
);

  localparam int TAP_W = $clog2(TAP_COUNT);
  localparam int CNT_W = $clog2(TAP_COUNT + 1);
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAP_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TAP_COUNT);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]       state_r,   state_nxt;
  logic [TAP_W-1:0] wr_ptr_r,  wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r,    fill_nxt;
  logic [TAP_W-1:0] rd_tap_r,  rd_tap_nxt;
  logic [TAP_W-1:0] rd_addr_r, rd_addr_nxt;
  logic             frame_r;

  logic             out_valid_r;
  logic signed [fir17_pkg::SAMPLE_W-1:0] out_data_r;
  logic             out_frame_r;

  logic             in_xfer;
  logic             out_free;
  logic             res_take;
  logic             res_valid;
  logic signed [fir17_pkg::SAMPLE_W-1:0] res_data;
  logic [fir17_pkg::SAMPLE_W-1:0] rd_data;
  fir17_pkg::tap_ctl_t tap_ctl;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign res_take    = (state_r == ST_WAIT) && res_valid && out_free;

  // Issue one tap read per cycle while walking the history
  always_comb begin
    tap_ctl.valid = (state_r == ST_READ);
    tap_ctl.first = (rd_tap_r == '0);
    tap_ctl.last  = (rd_tap_r == LAST_TAP);
    tap_ctl.live  = (CNT_W'(rd_tap_r) < fill_r);
  end

  // Sequence the item: write, walk the taps, hand off the result
  always_comb begin
    state_nxt   = state_r;
    wr_ptr_nxt  = wr_ptr_r;
    fill_nxt    = fill_r;
    rd_tap_nxt  = rd_tap_r;
    rd_addr_nxt = rd_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt   = ST_READ;
          rd_tap_nxt  = '0;
          rd_addr_nxt = wr_ptr_r;
          wr_ptr_nxt  = (wr_ptr_r == LAST_TAP) ? '0 : wr_ptr_r + 1'b1;
          if (fill_r != FULL_CNT) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_tap_nxt  = rd_tap_r + 1'b1;
        rd_addr_nxt = (rd_addr_r == '0) ? LAST_TAP : rd_addr_r - 1'b1;
        if (rd_tap_r == LAST_TAP) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Update the control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      rd_tap_r    <= '0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      fill_r    <= fill_nxt;
      rd_tap_r  <= rd_tap_nxt;
      rd_addr_r <= rd_addr_nxt;
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the frame flag and the output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_r <= in_ch.frame_end_in;
    end
    if (res_take) begin
      out_data_r  <= res_data;
      out_frame_r <= frame_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.filtered_out  = out_data_r;
  assign out_ch.frame_end_out = out_frame_r;

  fir17_ram #(
    .WIDTH (fir17_pkg::SAMPLE_W),
    .DEPTH (TAP_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wr_ptr_r),
    .wdata (in_ch.sample_in),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  fir17_mac #(
    .TAP_COUNT  (TAP_COUNT),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_ctl   (tap_ctl),
    .tap_idx   (rd_tap_r),
    .rd_data   (rd_data),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

// ----- bench/fir17_tb_pkg.sv -----
`timescale 1ns / 1ps

package fir17_tb_pkg;
  import fir17_pkg::SAMPLE_W;

  localparam int N_TAPS    = 17;
  localparam int ACC_SHIFT = 15;

  // Band-pass table in Q0.15, newest tap first
  localparam int BP_COEF [N_TAPS] = '{
    -23, -3, 56, 157, 305, 495, 711, 927, 1114,
    1239, 1278, 1239, 1114, 927, 711, 495, 305
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t filtered;
    logic    frame_end;
  } filtered_item_t;

  class bandpass_scoreboard;
    sample_t        history [N_TAPS];
    int unsigned    wr_ptr;
    filtered_item_t filtered_q [$];
    int unsigned    errors;
    int unsigned    n_samples;
    int unsigned    n_frame_ends;
    int unsigned    n_results;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_ptr       = 0;
      errors       = 0;
      n_samples    = 0;
      n_frame_ends = 0;
      n_results    = 0;
    endfunction

    // Store the sample, run the 17-tap sum and queue the filtered value
    function void push_sample(sample_t s, logic fe);
      logic signed [63:0] acc;
      logic signed [63:0] y;
      filtered_item_t     item;
      int unsigned        idx;
      history[wr_ptr] = s;
      acc = '0;
      for (int j = 0; j < N_TAPS; j++) begin
        idx = (wr_ptr + N_TAPS - j) % N_TAPS;
        acc += history[idx] * BP_COEF[j];
      end
      y = acc >>> ACC_SHIFT;
      // Clamp to the 32-bit output range
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      wr_ptr = (wr_ptr + 1) % N_TAPS;
      item.filtered  = y[SAMPLE_W-1:0];
      item.frame_end = fe;
      filtered_q.push_back(item);
      n_samples++;
      if (fe) n_frame_ends++;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one output transfer with the oldest queued value
    task check_filtered(sample_t got, logic got_fe);
      filtered_item_t exp_item;
      n_results++;
      if (filtered_q.size() == 0) begin
        report($sformatf("unexpected result %0d (frame_end %0b)", got, got_fe));
      end else begin
        exp_item = filtered_q.pop_front();
        if (got !== exp_item.filtered)
          report($sformatf("result %0d: filtered_out %0d, expected %0d",
                           n_results, got, exp_item.filtered));
        if (got_fe !== exp_item.frame_end)
          report($sformatf("result %0d: frame_end_out %0b, expected %0b",
                           n_results, got_fe, exp_item.frame_end));
      end
    endtask

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import fir17_tb_pkg::*;

  typedef enum int {
    BURST_PEAK_POS,
    BURST_PEAK_NEG,
    BURST_ALL_MAX,
    BURST_ALL_MIN
  } burst_kind_e;

  localparam sample_t S_MAX = 32'sh7FFFFFFF;
  localparam sample_t S_MIN = 32'sh80000000;
  localparam int      ITEMS_PER_PHASE = 183;
  localparam int      HOLD_CYCLES     = 300;

  logic clk;
  logic rst_n;

  fir17_in_if  in_ch ();
  fir17_out_if out_ch ();

  fir_17_tap_bandpass i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bandpass_scoreboard sb;

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_len;
  logic hold_tog;
  logic hold_seen;
  int hold_left;
  int n_bursts;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Give up if the run hangs
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Record every input transfer in the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.push_sample(in_ch.sample_in, in_ch.frame_end_in);
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_filtered(out_ch.filtered_out, out_ch.frame_end_out);
  end

  // Drive ready: random idling, or a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    hold_seen    <= 1'b0;
    hold_left    <= 0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen    <= hold_tog;
        hold_left    <= hold_len;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_sample(input sample_t s, input logic fe);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_in    <= s;
    in_ch.frame_end_in <= fe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Seventeen full-scale samples; the peak kinds match the coefficient signs
  task automatic send_burst(input burst_kind_e kind, input logic last_fe);
    sample_t s;
    for (int k = 0; k < N_TAPS; k++) begin
      case (kind)
        BURST_PEAK_POS: s = (BP_COEF[N_TAPS-1-k] < 0) ? S_MIN : S_MAX;
        BURST_PEAK_NEG: s = (BP_COEF[N_TAPS-1-k] < 0) ? S_MAX : S_MIN;
        BURST_ALL_MAX:  s = S_MAX;
        default:        s = S_MIN;
      endcase
      send_sample(s, (k == N_TAPS - 1) ? last_fe : 1'b0);
    end
    n_bursts++;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(9))
      0:       s = S_MIN;
      1:       s = S_MAX;
      2:       s = sample_t'($signed($urandom_range(2000)) - 1000);
      3, 4, 5: s = {24'($urandom_range(32'hFFFFFF, 0)), 8'h00};
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // Stop offering until every queued result has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic hold_receiver(input int len);
    hold_len <= len;
    hold_tog <= ~hold_tog;
  endtask

  initial begin
    int  sent;
    bit  held;
    sb = new();
    n_bursts     = 0;
    snd_idle_pct = 28;
    rcv_idle_pct = 55;
    hold_tog     = 1'b0;
    hold_len     = 0;
    held         = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_in    <= '0;
    in_ch.frame_end_in <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: start-up from an empty history, field extremes, peak output
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-32'sd1, 1'b1);
    send_burst(BURST_PEAK_POS, 1'b1);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh7FFFFF00, 1'b1);
    drain_results();

    // Random: three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 28; rcv_idle_pct = 55; end
        1: begin snd_idle_pct = 55; rcv_idle_pct = 28; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Stall the output while the input keeps offering
        if (!held && phase == 0 && sent >= 90) begin
          hold_receiver(HOLD_CYCLES);
          held = 1'b1;
        end
        if ($urandom_range(19) == 0) begin
          send_burst(burst_kind_e'($urandom_range(3)), 1'($urandom_range(1)));
          sent += N_TAPS;
        end else begin
          send_sample(rand_sample(), ($urandom_range(7) == 0));
          sent++;
        end
        if ($urandom_range(59) == 0) drain_results();
      end
      drain_results();
    end

    // Let any stray output show up
    repeat (30) @(posedge clk);

    $display("Run covered %0d samples, %0d frame ends, %0d results, %0d full-scale bursts,",
             sb.n_samples, sb.n_frame_ends, sb.n_results, n_bursts);
    $display("start-up from reset, history wrap, a %0d-cycle output stall and drains.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
